### hdl/tpft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpft_pkg;

    localparam int PT_W       = 32;               // coordinate width on the ports
    localparam int GUARD_BITS = 8;                // extra fraction bits on the point
    localparam int GAIN_FRAC  = 30;               // gain constant is Q1.30
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int DIF_W      = PT_W + 1;         // pivot difference, offset point
    localparam int NRM_W      = DIF_W + 1;        // direction after the pi pre-rotation
    localparam int DIR_W      = PT_W + 4;         // normalised direction, with CORDIC growth
    localparam int VEC_W      = DIF_W + GUARD_BITS + 3;  // point inside the rotator

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_ONE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_ONE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_TWO_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_TWO_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = 3'd4;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [PT_W-1:0] mapped_x;
        logic signed [PT_W-1:0] mapped_y;
        logic                   saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [PT_W-1:0] pivot_one_x;
        logic signed [PT_W-1:0] pivot_one_y;
        logic signed [PT_W-1:0] pivot_two_x;
        logic signed [PT_W-1:0] pivot_two_y;
        logic                   direction_mode;
    } t_cfg;

    // Item inside the rotator: direction being vectored and the point riding along
    typedef struct packed {
        logic                    zero;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
    } t_vec;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        int          j;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (j = 0; j < 32; j++) begin
            if (b != '0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        int          j;
        q   = '0;
        rem = '0;
        for (j = 63; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= den) begin
                rem  = rem - den;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Product of 1/sqrt(1+4^-i) over the stages, Q1.30, rounded after each factor
    function automatic logic [63:0] cordic_gain(input int stages);
        logic [63:0] k;
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] f;
        int          i;
        k = 64'd1 << GAIN_FRAC;
        for (i = 0; i < 32; i++) begin
            if (i < stages) begin
                n = 64'd1 << 60;
                if (2 * i <= 60) begin
                    n = n + (64'd1 << (60 - 2 * i));
                end
                s = isqrt64(n);
                f = udiv64((64'd1 << 60) + (s >> 1), s);
                k = (k * f + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/tpft_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module tpft_prep
    import tpft_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_stall,
    output logic          o_valid,
    output t_vec          o_data,
    input  wire logic     i_stall
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG:0]   stall;

    // stage 1: offset point (in direction mode) and pivot difference
    logic signed [DIF_W-1:0] r1_px, r1_py, r1_dx, r1_dy;
    logic signed [DIF_W-1:0] n1_px, n1_py, n1_dx, n1_dy;
    // stage 2: pi pre-rotation
    logic signed [NRM_W-1:0] r2_dx, r2_dy, n2_dx, n2_dy;
    logic signed [VEC_W-1:0] r2_vx, r2_vy, n2_vx, n2_vy;
    logic                    r2_zero, n2_zero;
    // stage 3: coarse normalisation in byte steps
    logic signed [NRM_W-1:0] r3_dx, r3_dy, n3_dx, n3_dy;
    logic        [DIF_W-1:0] r3_mag, n3_mag;
    logic signed [VEC_W-1:0] r3_vx, r3_vy;
    logic                    r3_zero;
    // stage 4: fine normalisation
    t_vec                    r4, n4;

    logic signed [NRM_W-1:0] ady;
    logic signed [NRM_W-1:0] mag_s;
    logic        [2:0]       cg;
    logic        [2:0]       fs;
    logic signed [VEC_W-1:0] vx_e, vy_e;
    int                      g;
    int                      j;

    assign stall[NSTG] = i_stall;
    for (genvar k = 0; k < NSTG; k++) begin : g_stall
        assign stall[k] = r_v[k] & stall[k+1];
    end
    assign o_stall = stall[0];
    assign n_v     = {r_v[NSTG-2:0], i_valid};

    always_comb begin
        n1_px = $signed({i_data.point_x[PT_W-1], i_data.point_x});
        n1_py = $signed({i_data.point_y[PT_W-1], i_data.point_y});
        if (i_cfg.direction_mode) begin
            n1_px = n1_px - $signed({i_cfg.pivot_one_x[PT_W-1], i_cfg.pivot_one_x});
            n1_py = n1_py - $signed({i_cfg.pivot_one_y[PT_W-1], i_cfg.pivot_one_y});
        end
        n1_dx = $signed({i_cfg.pivot_two_x[PT_W-1], i_cfg.pivot_two_x})
              - $signed({i_cfg.pivot_one_x[PT_W-1], i_cfg.pivot_one_x});
        n1_dy = $signed({i_cfg.pivot_two_y[PT_W-1], i_cfg.pivot_two_y})
              - $signed({i_cfg.pivot_one_y[PT_W-1], i_cfg.pivot_one_y});
    end

    always_comb begin
        vx_e = $signed({{(VEC_W-DIF_W){r1_px[DIF_W-1]}}, r1_px}) <<< GUARD_BITS;
        vy_e = $signed({{(VEC_W-DIF_W){r1_py[DIF_W-1]}}, r1_py}) <<< GUARD_BITS;
        n2_dx = $signed({r1_dx[DIF_W-1], r1_dx});
        n2_dy = $signed({r1_dy[DIF_W-1], r1_dy});
        n2_vx = vx_e;
        n2_vy = vy_e;
        // rotate by pi when the direction points into the left half plane
        if (r1_dx[DIF_W-1]) begin
            n2_dx = -n2_dx;
            n2_dy = -n2_dy;
            n2_vx = -vx_e;
            n2_vy = -vy_e;
        end
        n2_zero = (r1_dx == '0) && (r1_dy == '0);
    end

    always_comb begin
        ady    = r2_dy[NRM_W-1] ? -r2_dy : r2_dy;
        mag_s  = (r2_dx > ady) ? r2_dx : ady;
        cg     = 3'd4;
        for (g = 3; g >= 0; g--) begin
            if (mag_s[DIF_W-1-8*g -: 8] != '0) begin
                cg = 3'(g);
            end
        end
        n3_dx  = r2_dx <<< {cg, 3'b000};
        n3_dy  = r2_dy <<< {cg, 3'b000};
        n3_mag = mag_s[DIF_W-1:0] << {cg, 3'b000};
    end

    always_comb begin
        fs = 3'd7;
        for (j = 0; j < 8; j++) begin
            if (r3_mag[DIF_W-8+j]) begin
                fs = 3'(7 - j);
            end
        end
        n4.zero  = r3_zero;
        n4.dir_x = $signed({{(DIR_W-NRM_W){r3_dx[NRM_W-1]}}, r3_dx}) <<< fs;
        n4.dir_y = $signed({{(DIR_W-NRM_W){r3_dy[NRM_W-1]}}, r3_dy}) <<< fs;
        n4.vec_x = r3_vx;
        n4.vec_y = r3_vy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (!stall[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            r1_px <= n1_px;
            r1_py <= n1_py;
            r1_dx <= n1_dx;
            r1_dy <= n1_dy;
        end
        if (!stall[1]) begin
            r2_dx   <= n2_dx;
            r2_dy   <= n2_dy;
            r2_vx   <= n2_vx;
            r2_vy   <= n2_vy;
            r2_zero <= n2_zero;
        end
        if (!stall[2]) begin
            r3_dx   <= n3_dx;
            r3_dy   <= n3_dy;
            r3_mag  <= n3_mag;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_zero <= r2_zero;
        end
        if (!stall[3]) begin
            r4 <= n4;
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_data  = r4;

    // after the byte step the leading one must sit in the top byte
    a_coarse_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !r3_zero |-> r3_mag[DIF_W-1 -: 8] != '0)
        else $error("coarse normalisation left the top byte empty");

endmodule

`default_nettype wire

### hdl/tpft_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module tpft_cordic
    import tpft_pkg::*;
#(
    parameter int STAGES = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_inverse,
    input  wire logic i_valid,
    input  wire t_vec i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_vec      o_data,
    input  wire logic i_stall
);

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES:0]   stall;
    t_vec              r_d [STAGES];
    t_vec              n_d [STAGES];

    assign stall[STAGES] = i_stall;
    for (genvar k = 0; k < STAGES; k++) begin : g_stall
        assign stall[k] = r_v[k] & stall[k+1];
    end
    assign o_stall = stall[0];

    if (STAGES > 1) begin : g_vshift
        assign n_v = {r_v[STAGES-2:0], i_valid};
    end else begin : g_vone
        assign n_v = i_valid;
    end

    // one micro-rotation per stage; the direction picks the sense, the point follows
    always_comb begin
        t_vec                    cur;
        logic                    cw;
        logic signed [DIR_W-1:0] dx, dy;
        logic signed [VEC_W-1:0] vx, vy;
        int                      k;
        for (k = 0; k < STAGES; k++) begin
            cur = (k == 0) ? i_data : r_d[(k == 0) ? 0 : k - 1];
            dx  = cur.dir_x;
            dy  = cur.dir_y;
            vx  = cur.vec_x;
            vy  = cur.vec_y;
            cw  = !dy[DIR_W-1];
            n_d[k] = cur;
            if (!cur.zero) begin
                if (cw) begin
                    n_d[k].dir_x = dx + (dy >>> k);
                    n_d[k].dir_y = dy - (dx >>> k);
                end else begin
                    n_d[k].dir_x = dx - (dy >>> k);
                    n_d[k].dir_y = dy + (dx >>> k);
                end
                if (cw == i_inverse) begin
                    n_d[k].vec_x = vx + (vy >>> k);
                    n_d[k].vec_y = vy - (vx >>> k);
                end else begin
                    n_d[k].vec_x = vx - (vy >>> k);
                    n_d[k].vec_y = vy + (vx >>> k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (!stall[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (!stall[k]) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_data  = r_d[STAGES-1];

    // vectoring drives the direction onto the positive x axis
    a_vector_xpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES-1] && !r_d[STAGES-1].zero |-> !r_d[STAGES-1].dir_x[DIR_W-1])
        else $error("vectored direction left the right half plane");

endmodule

`default_nettype wire

### hdl/tpft_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module tpft_scale
    import tpft_pkg::*;
#(
    parameter int STAGES = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire t_vec i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  wire logic i_stall
);

    localparam int NSTG   = 4;
    localparam int SCL    = GAIN_FRAC + GUARD_BITS;     // final right shift
    localparam int HI_W   = VEC_W - 32;
    localparam int PLO_W  = 32 + GAIN_W;
    localparam int PHI_W  = HI_W + GAIN_W;
    localparam int SUM1_W = PHI_W + 1;
    localparam int RES_W  = SUM1_W - (SCL - 32);
    localparam int BYP_W  = VEC_W - GUARD_BITS;
    localparam int SUM_W  = RES_W + 2;

    localparam logic [63:0]       GAIN_FULL = cordic_gain(STAGES);
    localparam logic [GAIN_W-1:0] GAIN      = GAIN_FULL[GAIN_W-1:0];
    localparam logic [63:0]       RND       = 64'd1 << (SCL - 1);
    localparam logic signed [PT_W-1:0] MAX_V = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] MIN_V = {1'b1, {(PT_W-1){1'b0}}};

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG:0]   stall;

    // stage A: sign and magnitude
    logic [VEC_W-1:0] ra_mx, ra_my;
    logic             ra_negx, ra_negy, ra_zero;
    // stage B: partial products with the gain
    logic [PLO_W-1:0] rb_lox, rb_loy;
    logic [PHI_W-1:0] rb_hix, rb_hiy;
    logic [BYP_W-1:0] rb_bx, rb_by;
    logic             rb_negx, rb_negy, rb_zero;
    // stage C: rounded magnitude
    logic [RES_W-1:0] rc_mx, rc_my, nc_mx, nc_my;
    logic             rc_negx, rc_negy;
    // stage D: output register
    t_out_item        r_out, n_out;

    logic [63:0]             lox_r, loy_r;
    logic [SUM1_W-1:0]       tx, ty;
    logic signed [SUM_W-1:0] sx, sy;
    logic signed [SUM_W-1:0] offx, offy;
    logic                    ovx, ovy;

    assign stall[NSTG] = i_stall;
    for (genvar k = 0; k < NSTG; k++) begin : g_stall
        assign stall[k] = r_v[k] & stall[k+1];
    end
    assign o_stall = stall[0];
    assign n_v     = {r_v[NSTG-2:0], i_valid};

    always_comb begin
        lox_r = {{(64-PLO_W){1'b0}}, rb_lox} + RND;
        loy_r = {{(64-PLO_W){1'b0}}, rb_loy} + RND;
        tx    = {1'b0, rb_hix} + SUM1_W'(lox_r[63:32]);
        ty    = {1'b0, rb_hiy} + SUM1_W'(loy_r[63:32]);
        nc_mx = tx[SUM1_W-1 -: RES_W];
        nc_my = ty[SUM1_W-1 -: RES_W];
        // coincident pivots: the point was only widened, so drop the guard bits exactly
        if (rb_zero) begin
            nc_mx = RES_W'(rb_bx);
            nc_my = RES_W'(rb_by);
        end
    end

    always_comb begin
        offx = '0;
        offy = '0;
        if (!i_cfg.direction_mode) begin
            offx = SUM_W'(i_cfg.pivot_one_x);
            offy = SUM_W'(i_cfg.pivot_one_y);
        end
        sx = (rc_negx ? -$signed({2'b00, rc_mx}) : $signed({2'b00, rc_mx})) + offx;
        sy = (rc_negy ? -$signed({2'b00, rc_my}) : $signed({2'b00, rc_my})) + offy;
        ovx = !((&sx[SUM_W-1:PT_W-1]) || !(|sx[SUM_W-1:PT_W-1]));
        ovy = !((&sy[SUM_W-1:PT_W-1]) || !(|sy[SUM_W-1:PT_W-1]));
        n_out.mapped_x  = ovx ? (sx[SUM_W-1] ? MIN_V : MAX_V) : sx[PT_W-1:0];
        n_out.mapped_y  = ovy ? (sy[SUM_W-1] ? MIN_V : MAX_V) : sy[PT_W-1:0];
        n_out.saturated = ovx | ovy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (!stall[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            ra_negx <= i_data.vec_x[VEC_W-1];
            ra_negy <= i_data.vec_y[VEC_W-1];
            ra_mx   <= i_data.vec_x[VEC_W-1] ? VEC_W'(-i_data.vec_x) : VEC_W'(i_data.vec_x);
            ra_my   <= i_data.vec_y[VEC_W-1] ? VEC_W'(-i_data.vec_y) : VEC_W'(i_data.vec_y);
            ra_zero <= i_data.zero;
        end
        if (!stall[1]) begin
            rb_lox  <= ra_mx[31:0] * GAIN;
            rb_loy  <= ra_my[31:0] * GAIN;
            rb_hix  <= ra_mx[VEC_W-1:32] * GAIN;
            rb_hiy  <= ra_my[VEC_W-1:32] * GAIN;
            rb_bx   <= ra_mx[VEC_W-1:GUARD_BITS];
            rb_by   <= ra_my[VEC_W-1:GUARD_BITS];
            rb_negx <= ra_negx;
            rb_negy <= ra_negy;
            rb_zero <= ra_zero;
        end
        if (!stall[2]) begin
            rc_mx   <= nc_mx;
            rc_my   <= nc_my;
            rc_negx <= rb_negx;
            rc_negy <= rb_negy;
        end
        if (!stall[3]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_data  = r_out;

    // a clipped result must sit on one of the range limits
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && r_out.saturated |->
            r_out.mapped_x == MAX_V || r_out.mapped_x == MIN_V ||
            r_out.mapped_y == MAX_V || r_out.mapped_y == MIN_V)
        else $error("saturated flag without a clipped coordinate");

endmodule

`default_nettype wire

### hdl/two_pivot_frame_transform.sv
// Throughput: one point per cycle while o_stall is low; each stage holds its item
// under stall and empty stages keep filling, so input transfers continue while a
// result waits. Depth is the preparation stages, then one register stage per CORDIC
// micro-rotation in the rotator, then the scaling stages. Reset (i_rst_n, synchronous,
// active low) empties the pipeline and sets all pivots and the mode to zero.
`timescale 1ns / 1ps
`default_nettype none

module two_pivot_frame_transform
    import tpft_pkg::*;
#(
    parameter int ANGLE_STAGES = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PT_W-1:0]      i_cfg_data,
    input  wire logic                 i_valid,
    input  wire t_in_item             i_data,
    output logic                      o_stall,
    output logic                      o_valid,
    output t_out_item                 o_data,
    input  wire logic                 i_stall
);

    t_cfg r_cfg;

    logic prep_valid, prep_stall;
    t_vec prep_data;
    logic rot_valid, rot_stall;
    t_vec rot_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIVOT_ONE_X:    r_cfg.pivot_one_x    <= i_cfg_data;
                CFG_PIVOT_ONE_Y:    r_cfg.pivot_one_y    <= i_cfg_data;
                CFG_PIVOT_TWO_X:    r_cfg.pivot_two_x    <= i_cfg_data;
                CFG_PIVOT_TWO_Y:    r_cfg.pivot_two_y    <= i_cfg_data;
                CFG_DIRECTION_MODE: r_cfg.direction_mode <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    tpft_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (prep_valid),
        .o_data  (prep_data),
        .i_stall (prep_stall)
    );

    tpft_cordic #(
        .STAGES (ANGLE_STAGES)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inverse (r_cfg.direction_mode),
        .i_valid   (prep_valid),
        .i_data    (prep_data),
        .o_stall   (prep_stall),
        .o_valid   (rot_valid),
        .o_data    (rot_data),
        .i_stall   (rot_stall)
    );

    tpft_scale #(
        .STAGES (ANGLE_STAGES)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (rot_valid),
        .i_data  (rot_data),
        .o_stall (rot_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // back-pressure at the input can only come from a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled while the output is free");

endmodule

`default_nettype wire
